[rtl/core/ajrb_pkg.sv]
// Shared types and constants for the audio jitter ring buffer.
// Holds the channel word structs, request codes and ring sizing.
// No dependencies.
`default_nettype none

package ajrb_pkg;

  // Ring depth must be a power of two: pointers wrap by truncation.
  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned MAX_PULL = 64;

  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned LVL_W    = 12;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned CMP_W    = (ADDR_W > LVL_W) ? ADDR_W : LVL_W;
  localparam int unsigned DROP_N   = (DEPTH / 8 < 1) ? 1 : DEPTH / 8;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_PULL  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREBUFFER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [SMP_W-1:0] sample_in;
    logic [CNT_W-1:0]        pull_count;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    from_ring;
    logic                    block_ok;
    logic                    last;
    logic [LVL_W-1:0]        fill_after;
  } out_word_t;

  typedef struct packed {
    logic             enabled;
    logic [LVL_W-1:0] prebuffer_level;
    logic [LVL_W-1:0] high_level;
    logic [LVL_W-1:0] target_level;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_PULL
  } state_t;

endpackage

`default_nettype wire

[rtl/core/ajrb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Read during write to the same address returns the old data.
// No dependencies.
`default_nettype none

module ajrb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/ajrb_cfg.sv]
// Configuration register file for the jitter ring buffer.
// Depends on ajrb_pkg for register indexes and the cfg_t struct.
`default_nettype none

module ajrb_cfg
  import ajrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LVL_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLED:   cfg_nxt.enabled         = cfg_wdata[0];
        CFG_PREBUFFER: cfg_nxt.prebuffer_level = cfg_wdata;
        CFG_HIGH:      cfg_nxt.high_level      = cfg_wdata;
        CFG_TARGET:    cfg_nxt.target_level    = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b1;
      cfg_r.prebuffer_level <= LVL_W'(400);
      cfg_r.high_level      <= LVL_W'(2666);
      cfg_r.target_level    <= LVL_W'(800);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/core/ajrb_ctrl.sv]
// Pointer control, pull sequencer and output register of the ring buffer.
// Depends on ajrb_pkg; drives the write and read ports of the sample RAM.
`default_nettype none

module ajrb_ctrl
  import ajrb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_data,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [SMP_W-1:0]       ram_wdata,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire logic [SMP_W-1:0]  ram_rdata
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] rp_r, rp_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic              live_r, live_nxt;
  logic              got_r, got_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              in_fire;
  logic              is_pull;
  logic              out_take;
  logic              emit;
  logic [ADDR_W-1:0] fill;
  logic [CMP_W-1:0]  fill_ext;
  logic [ADDR_W-1:0] fill_post;
  logic              from;
  logic              fill_live;

  assign fill     = wp_r - rp_r;
  assign fill_ext = CMP_W'(fill);
  assign in_fire  = in_valid && (state_r == ST_IDLE);
  assign is_pull  = (in_data.req_type == REQ_PULL) && (in_data.pull_count != '0);
  assign out_take = out_valid_r && !out_stall;
  assign emit     = (state_r == ST_PULL) && (!out_valid_r || !out_stall);
  assign from     = live_r && (fill != '0);
  assign fill_post = fill - ADDR_W'(from);
  assign fill_live = cfg.enabled && (fill_ext >= CMP_W'(cfg.prebuffer_level));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire && is_pull) state_nxt = ST_PULL;
      ST_PULL: if (emit && rem_r == CNT_W'(1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    live_nxt     = live_r;
    got_nxt      = got_r;
    rem_nxt      = rem_r;
    out_word_nxt = out_word_r;
    out_valid_nxt = out_valid_r && !out_take;
    ram_we       = 1'b0;

    if (in_fire) begin
      unique case (in_data.req_type)
        REQ_PUSH: begin
          // drop the oldest block when the ring is full
          if (fill == ADDR_W'(DEPTH - 1)) rp_nxt = rp_r + ADDR_W'(DROP_N);
          ram_we = 1'b1;
          wp_nxt = wp_r + ADDR_W'(1);
        end
        REQ_CLEAR: rp_nxt = wp_r;
        REQ_PULL: begin
          if (is_pull) begin
            live_nxt = fill_live;
            got_nxt  = 1'b0;
            rem_nxt  = (in_data.pull_count > CNT_W'(MAX_PULL)) ? CNT_W'(MAX_PULL)
                                                               : in_data.pull_count;
            // above the high level, trim down to the target level
            if (fill_live && fill_ext > CMP_W'(cfg.high_level) &&
                fill_ext > CMP_W'(cfg.target_level)) begin
              rp_nxt = ADDR_W'(CMP_W'(wp_r) - CMP_W'(cfg.target_level));
            end
          end
        end
        default: ;
      endcase
    end

    if (emit) begin
      rp_nxt  = rp_r + ADDR_W'(from);
      rem_nxt = rem_r - CNT_W'(1);
      got_nxt = got_r || from;
      out_word_nxt.sample_out = from ? $signed(ram_rdata) : '0;
      out_word_nxt.from_ring  = from;
      out_word_nxt.last       = (rem_r == CNT_W'(1));
      out_word_nxt.block_ok   = (rem_r == CNT_W'(1)) && (got_r || from);
      out_word_nxt.fill_after = LVL_W'(CMP_W'(fill_post));
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      live_r      <= 1'b0;
      got_r       <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      live_r      <= live_nxt;
      got_r       <= got_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // Read ahead at the next read pointer so the sample is ready when emitted
  assign ram_raddr = rp_nxt;
  assign ram_waddr = wp_r;
  assign ram_wdata = in_data.sample_in;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

[rtl/core/audio_jitter_ring_buffer_core.sv]
// Audio jitter ring buffer: 16-bit sample ring with a jitter-buffer pull policy.
// Input words carry a request: push one sample, pull a block, or clear the ring.
// A push or clear gives no output word. A pull of N samples (N clamped to 64)
// gives N output words, one per cycle while the receiver does not stall, the
// first once the sequencer is in its pull state. The rate is set by the single
// registered read port of the sample RAM, which is read ahead one sample.
// in_stall stays high while a pull is being emitted, so the next input word is
// taken the cycle after the last output word is loaded. A stall on the output
// holds the output register and pauses the pull sequence; pushes still go in
// while the last word waits. Configuration writes are registered; the user
// must issue them while idle, which the block itself does not enforce.
// Reset empties the ring (pointers to zero) and loads the register defaults:
// enabled, prebuffer 400, high 2666, target 800. The sample RAM is not
// cleared; only written entries are ever read.
// Depends on ajrb_pkg, ajrb_cfg, ajrb_ctrl and ajrb_ram.
`default_nettype none

module audio_jitter_ring_buffer_core
  import ajrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LVL_W-1:0]     cfg_wdata
);

  cfg_t              cfg;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SMP_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SMP_W-1:0]  ram_rdata;

  ajrb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ajrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ajrb_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A pull with a nonzero count blocks the input on the next cycle
  a_pull_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.req_type == REQ_PULL && in_data.pull_count != '0)
      |=> in_stall)
    else $error("pull did not start the sequencer");

  // Zero fill words carry a zero sample
  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.from_ring) |-> (out_data.sample_out == '0))
    else $error("zero fill word carries data");

  // The ok flag only appears on the final word of a block
  a_ok_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.block_ok) |-> out_data.last)
    else $error("block_ok set on a non-final word");

endmodule

`default_nettype wire

[sim/audio_jitter_ring_buffer_checker.sv]
// Scoreboard for audio_jitter_ring_buffer_core: shadows the sample ring and the
// level registers, predicts every pulled word and compares it on the output.
// Depends on ajrb_pkg.
module audio_jitter_ring_buffer_checker
  import ajrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LVL_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SMP_W-1:0]  ring_store [DEPTH];
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] wr_ptr;
  cfg_t              levels;
  out_word_t         expected_words [$];
  int                errors = 0;

  function automatic int ring_fill();
    logic [ADDR_W-1:0] span;
    span = wr_ptr - rd_ptr;
    return int'(span);
  endfunction

  function automatic void drop_oldest(int n);
    int held;
    held = ring_fill();
    if (n > held) n = held;
    rd_ptr = rd_ptr + ADDR_W'(n);
  endfunction

  task automatic report_failure(string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, what);
  endtask

  // Update the shadow ring for one accepted request and queue the pulled words.
  task automatic apply_request(in_word_t w);
    int        count;
    int        got;
    bit        live;
    out_word_t word;
    case (w.req_type)
      REQ_PUSH: begin
        if (ring_fill() >= DEPTH - 1) drop_oldest(DROP_N);
        ring_store[wr_ptr] = w.sample_in;
        wr_ptr = wr_ptr + 1'b1;
      end
      REQ_CLEAR: rd_ptr = wr_ptr;
      REQ_PULL: begin
        if (w.pull_count != 0) begin
          count = w.pull_count;
          if (count > MAX_PULL) count = MAX_PULL;
          live = levels.enabled && ring_fill() >= levels.prebuffer_level;
          // trim back to target only when the ring sits above the high mark
          if (live && ring_fill() > levels.high_level && ring_fill() > levels.target_level)
            drop_oldest(ring_fill() - levels.target_level);
          got = 0;
          for (int k = 0; k < count; k++) begin
            word = '0;
            if (live && ring_fill() > 0) begin
              word.sample_out = ring_store[rd_ptr];
              word.from_ring  = 1'b1;
              rd_ptr = rd_ptr + 1'b1;
              got++;
            end
            word.last       = (k == count - 1);
            word.block_ok   = word.last && got > 0;
            word.fill_after = LVL_W'(ring_fill());
            expected_words.push_back(word);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      rd_ptr = '0;
      wr_ptr = '0;
      levels = '{enabled: 1'b1, prebuffer_level: 12'd400, high_level: 12'd2666,
                 target_level: 12'd800};
      expected_words.delete();
    end else begin
      // check the output first: a word leaving now never belongs to a pull taken now
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_failure($sformatf("unexpected word: sample %0d ring %0b ok %0b last %0b fill %0d",
                                   out_data.sample_out, out_data.from_ring, out_data.block_ok,
                                   out_data.last, out_data.fill_after));
        end else begin
          want = expected_words.pop_front();
          if (out_data.sample_out !== want.sample_out || out_data.from_ring !== want.from_ring ||
              out_data.block_ok !== want.block_ok || out_data.last !== want.last ||
              out_data.fill_after !== want.fill_after) begin
            report_failure($sformatf({"word mismatch: expected sample %0d ring %0b ok %0b ",
                                      "last %0b fill %0d, got sample %0d ring %0b ok %0b ",
                                      "last %0b fill %0d"},
                                     want.sample_out, want.from_ring, want.block_ok,
                                     want.last, want.fill_after, out_data.sample_out,
                                     out_data.from_ring, out_data.block_ok, out_data.last,
                                     out_data.fill_after));
          end
        end
      end
      if (in_valid && !in_stall) apply_request(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLED:   levels.enabled         = cfg_wdata[0];
          CFG_PREBUFFER: levels.prebuffer_level = cfg_wdata;
          CFG_HIGH:      levels.high_level      = cfg_wdata;
          CFG_TARGET:    levels.target_level    = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    pending_words  <= expected_words.size();
  end

endmodule

[sim/audio_jitter_ring_buffer_core_tb.sv]
// Top of the audio_jitter_ring_buffer_core testbench: clock, reset, request and
// level-register stimulus, output stalls and the verdict.
// Depends on ajrb_pkg, audio_jitter_ring_buffer_core and audio_jitter_ring_buffer_checker.
module audio_jitter_ring_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ajrb_pkg::*;

  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         DRAIN_CYCLES    = 16;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LVL_W-1:0]     cfg_wdata = '0;
  int                   mismatch_count;
  int                   pending_words;

  int send_idle_pct    = 30;
  int recv_idle_pct    = 61;
  bit hold_off_pending = 1'b0;

  audio_jitter_ring_buffer_core dut (.*);
  audio_jitter_ring_buffer_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_word_t make_word(logic [1:0] kind, logic [SMP_W-1:0] smp,
                                         logic [CNT_W-1:0] cnt);
    make_word.req_type   = kind;
    make_word.sample_in  = smp;
    make_word.pull_count = cnt;
  endfunction

  // Offer one word after a random gap and hold it until taken.
  task automatic send_word(in_word_t w);
    bit stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic push_sample(logic [SMP_W-1:0] smp);
    send_word(make_word(REQ_PUSH, smp, CNT_W'($urandom)));
  endtask

  task automatic pull_block(logic [CNT_W-1:0] n);
    send_word(make_word(REQ_PULL, SMP_W'($urandom), n));
  endtask

  task automatic clear_ring();
    send_word(make_word(REQ_CLEAR, SMP_W'($urandom), CNT_W'($urandom)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    // a trailing push may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_levels(logic en, logic [LVL_W-1:0] pre, logic [LVL_W-1:0] high,
                            logic [LVL_W-1:0] target);
    write_reg(CFG_ENABLED, LVL_W'(en));
    write_reg(CFG_PREBUFFER, pre);
    write_reg(CFG_HIGH, high);
    write_reg(CFG_TARGET, target);
  endtask

  task automatic randomize_levels();
    set_levels(1'b1, LVL_W'($urandom_range(0, 30)), LVL_W'($urandom_range(40, 200)),
               LVL_W'($urandom_range(0, 60)));
  endtask

  // Mostly push bursts and pulls with random content, some clears and junk words.
  task automatic random_items(int n);
    int done;
    int pick;
    int burst;
    int cnt;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_sample(SMP_W'($urandom));
        done++;
      end else if (pick < 58) begin
        burst = $urandom_range(3, 24);
        repeat (burst) push_sample(SMP_W'($urandom));
        done += burst;
      end else if (pick < 88) begin
        pick = $urandom_range(99);
        if (pick < 10) cnt = $urandom_range(0, 127);
        else if (pick < 30) cnt = $urandom_range(17, 64);
        else cnt = $urandom_range(1, 16);
        pull_block(CNT_W'(cnt));
        if (cnt != 0) done++;
      end else if (pick < 94) begin
        clear_ring();
        done++;
      end else begin
        send_word(make_word(REQ_UNUSED, SMP_W'($urandom), CNT_W'($urandom)));
      end
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset levels: fill is below prebuffer, so pulls give zero fill
    pull_block(7'd1);
    pull_block(7'd0);
    send_word(make_word(REQ_UNUSED, 16'hFFFF, 7'h7F));
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h5555);
    push_sample(16'hAAAA);
    pull_block(7'd127);
    wait_drained();

    set_levels(1'b1, '0, 12'hFFF, '0);
    pull_block(7'd4);
    pull_block(7'd5);
    pull_block(7'd2);
    push_sample(16'h1234);
    push_sample(16'hFEDC);
    push_sample(16'h0F0F);
    clear_ring();
    pull_block(7'd1);
    wait_drained();

    // disabled block still stores pushes
    write_reg(CFG_ENABLED, '0);
    push_sample(16'h0101);
    push_sample(16'hF0F0);
    pull_block(7'd2);
    wait_drained();
    write_reg(CFG_ENABLED, LVL_W'(1));
    pull_block(7'd64);
    wait_drained();

    // trim above high mark down to target
    set_levels(1'b1, '0, 12'd2, 12'd1);
    repeat (5) push_sample(SMP_W'($urandom));
    pull_block(7'd3);
    wait_drained();

    // target above fill: nothing to trim
    set_levels(1'b1, '0, '0, 12'hFFF);
    repeat (3) push_sample(SMP_W'($urandom));
    pull_block(7'd2);
    wait_drained();

    randomize_levels();
    random_items(37);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 30;
    randomize_levels();
    // hold the output off while the sender keeps offering words
    hold_off_pending = 1'b1;
    repeat (20) push_sample(SMP_W'($urandom));
    pull_block(7'd40);
    pull_block(7'd30);
    repeat (5) push_sample(SMP_W'($urandom));
    pull_block(7'd8);
    random_items(20);
    wait_drained();
    randomize_levels();
    random_items(20);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    randomize_levels();
    random_items(30);
    wait_drained();

    set_levels(1'b1, '0, '0, 12'hFFF);
    pull_block(7'd10);
    clear_ring();
    pull_block(7'd3);
    wait_drained();

    if (mismatch_count == 0 && pending_words == 0) begin
      $display("PASS audio_jitter_ring_buffer_core");
    end else begin
      $display("FAIL audio_jitter_ring_buffer_core");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("FAIL audio_jitter_ring_buffer_core");
    $finish;
  end

endmodule
